### rtl/cbp_pkg.sv
package cbp_pkg;

  // Field widths of the channels
  localparam int unsigned CoeffW     = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned FieldBitsW = 5;
  localparam int unsigned ModulusW   = 15;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] RegFieldBits = 1'b0;
  localparam logic [CfgIdxW-1:0] RegModulus   = 1'b1;

  localparam logic [FieldBitsW-1:0] FieldBitsRst = 5'd12;
  localparam logic [ModulusW-1:0]   ModulusRst   = 15'd3329;

  // Default for the widest kept field
  localparam int unsigned MaxFieldBitsDef = 16;

  // Sign bit of a coefficient
  localparam int unsigned SignBitPos = 15;

  // Output byte queue
  localparam int unsigned FifoDepth = 4;

  // Bytes released by one coefficient, handed from packer to queue
  typedef struct packed {
    logic [1:0]       cnt;
    logic [ByteW-1:0] byte0;
    logic             last0;
    logic [ByteW-1:0] byte1;
  } cbp_push_t;

  // One queued output word
  typedef struct packed {
    logic             last;
    logic [ByteW-1:0] data;
  } cbp_entry_t;

endpackage

### rtl/cbp_if.sv
interface cbp_coeff_if;
  logic                             valid;
  logic                             ready;
  logic signed [cbp_pkg::CoeffW-1:0] coeff;

  modport source (output valid, output coeff, input ready);
  modport sink   (input valid, input coeff, output ready);
endinterface

interface cbp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [cbp_pkg::ByteW-1:0] byte_out;
  logic                      last_of_run;

  modport source (output valid, output byte_out, output last_of_run, input ready);
  modport sink   (input valid, input byte_out, input last_of_run, output ready);
endinterface

interface cbp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cbp_pkg::CfgIdxW-1:0]  index;
  logic [cbp_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/cbp_pack.sv
module cbp_pack #(
  parameter int unsigned MaxFieldBits = cbp_pkg::MaxFieldBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  logic [cbp_pkg::CoeffW-1:0]        coeff_i,
  input  logic [cbp_pkg::FieldBitsW-1:0]    field_bits_i,
  input  logic [cbp_pkg::ModulusW-1:0]      modulus_i,
  output cbp_pkg::cbp_push_t                push_o
);

  localparam int unsigned ByteW = cbp_pkg::ByteW;
  localparam int unsigned CntW  = $clog2(ByteW);
  localparam int unsigned AccW  = MaxFieldBits + ByteW - 1;
  localparam int unsigned TotW  = $clog2(MaxFieldBits + ByteW);
  localparam int unsigned FbW   = cbp_pkg::FieldBitsW;

  logic [ByteW-2:0]                 acc_q, acc_d;
  logic [CntW-1:0]                  cnt_q, cnt_d;
  logic [FbW-1:0]                   width;
  logic [cbp_pkg::CoeffW-1:0]       coeff_adj;
  logic [MaxFieldBits-1:0]          mask;
  logic [MaxFieldBits-1:0]          field;
  logic [AccW-1:0]                  combined;
  logic [AccW-1:0]                  rest;
  logic [TotW-1:0]                  total;
  logic [TotW-1:0]                  used;
  logic [1:0]                       nbytes;

  // Saturate the field width
  assign width = (field_bits_i > FbW'(MaxFieldBits)) ? FbW'(MaxFieldBits) : field_bits_i;

  // Fold negative coefficients, keep the low field bits
  assign coeff_adj = coeff_i[cbp_pkg::SignBitPos]
                   ? coeff_i + cbp_pkg::CoeffW'(modulus_i)
                   : coeff_i;
  assign mask  = ~({MaxFieldBits{1'b1}} << width);
  assign field = coeff_adj[MaxFieldBits-1:0] & mask;

  // Append above the pending bits
  assign combined = AccW'(acc_q) | (AccW'(field) << cnt_q);
  assign total    = TotW'(cnt_q) + TotW'(width);

  always_comb begin
    if (total >= 2 * ByteW) begin
      nbytes = 2'd2;
    end else if (total >= ByteW) begin
      nbytes = 2'd1;
    end else begin
      nbytes = 2'd0;
    end
  end

  // Drop the released bytes from the accumulator
  assign used  = TotW'({nbytes, {CntW{1'b0}}});
  assign rest  = combined >> {nbytes, {CntW{1'b0}}};
  assign acc_d = rest[ByteW-2:0];
  assign cnt_d = CntW'(total - used);

  always_comb begin
    push_o.cnt   = take_i ? nbytes : 2'd0;
    push_o.byte0 = combined[ByteW-1:0];
    push_o.last0 = (nbytes == 2'd1);
    push_o.byte1 = ByteW'(combined >> ByteW);
  end

  // Advance the accumulator on each packed coefficient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (take_i) begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/cbp_fifo.sv
module cbp_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cbp_pkg::cbp_push_t      push_i,
  input  logic                    pop_i,
  output logic                    room_o,
  output logic                    valid_o,
  output cbp_pkg::cbp_entry_t     head_o
);

  localparam int unsigned Depth = cbp_pkg::FifoDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cbp_pkg::cbp_entry_t entry_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wptr_nxt;

  assign room_o   = (count_q <= CntW'(Depth - 2));
  assign valid_o  = (count_q != '0);
  assign head_o   = entry_q[rptr_q];
  assign wptr_nxt = wptr_q + PtrW'(1);

  assign wptr_d  = wptr_q + PtrW'(push_i.cnt);
  assign rptr_d  = pop_i ? rptr_q + PtrW'(1) : rptr_q;
  assign count_d = count_q + CntW'(push_i.cnt) - CntW'(pop_i);

  // Write up to two words per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entry_q[wptr_q] <= '{last: push_i.last0, data: push_i.byte0};
    end
    if (push_i.cnt == 2'd2) begin
      entry_q[wptr_nxt] <= '{last: 1'b1, data: push_i.byte1};
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

### rtl/coefficient_bit_packer.sv
// Channel   Dir  Payload                       Handshake
// cfg_i     in   index[0:0], data[14:0]        valid/ready, ready always high
// coeff_i   in   coeff[15:0] signed            valid/ready
// byte_o    out  byte_out[7:0], last_of_run    valid/ready
//
// One coefficient is accepted per cycle while the byte queue has room; it
// releases zero, one or two bytes. A byte passes through the input register
// and the byte queue before it shows on byte_o.
// The output port moves one word per cycle while byte_o.ready is high, so a
// two-byte coefficient needs two transfers; a four-word byte queue absorbs this.
// Reset clears the bit accumulator, the queue and restores the registers.
// Output stalls back up through the queue into the input register.
module coefficient_bit_packer #(
  parameter int unsigned MaxFieldBits = cbp_pkg::MaxFieldBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  cbp_cfg_if.sink            cfg_i,
  cbp_coeff_if.sink          coeff_i,
  cbp_byte_if.source         byte_o
);

  logic [cbp_pkg::FieldBitsW-1:0] field_bits_q;
  logic [cbp_pkg::ModulusW-1:0]   modulus_q;
  logic                           in_vld_q;
  logic [cbp_pkg::CoeffW-1:0]     coeff_q;
  logic                           take;
  logic                           room;
  logic                           pop;
  cbp_pkg::cbp_push_t             push;
  cbp_pkg::cbp_entry_t            head;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_bits_q <= cbp_pkg::FieldBitsRst;
      modulus_q    <= cbp_pkg::ModulusRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        cbp_pkg::RegFieldBits: field_bits_q <= cfg_i.data[cbp_pkg::FieldBitsW-1:0];
        cbp_pkg::RegModulus:   modulus_q    <= cfg_i.data[cbp_pkg::ModulusW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: refill while the held word drains
  assign take          = in_vld_q && room;
  assign coeff_i.ready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (coeff_i.ready) begin
      in_vld_q <= coeff_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (coeff_i.ready && coeff_i.valid) begin
      coeff_q <= coeff_i.coeff;
    end
  end

  cbp_pack #(
    .MaxFieldBits (MaxFieldBits)
  ) u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .coeff_i      (coeff_q),
    .field_bits_i (field_bits_q),
    .modulus_i    (modulus_q),
    .push_o       (push)
  );

  // Output queue
  assign pop = byte_o.valid && byte_o.ready;

  cbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (byte_o.valid),
    .head_o  (head)
  );

  assign byte_o.byte_out    = head.data;
  assign byte_o.last_of_run = head.last;

endmodule

### rtl/cbp_checker.sv
module cbp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_i,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [cbp_pkg::ByteW-1:0]  out_byte_i,
  input logic                       out_last_i
);

  // A stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled output word changed");

  // Configuration writes are never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write refused");

  // No output word while in reset
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // A byte that is not the last of its run is followed at once by another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("run broken after a non-last byte");

  // Output wakes up only after a coefficient is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("output word without a coefficient");

endmodule

bind coefficient_bit_packer cbp_checker u_cbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .in_valid_i  (coeff_i.valid),
  .in_ready_i  (coeff_i.ready),
  .out_valid_i (byte_o.valid),
  .out_ready_i (byte_o.ready),
  .out_byte_i  (byte_o.byte_out),
  .out_last_i  (byte_o.last_of_run)
);
